[rtl/smbios_entry_point_decoder_defines.svh]
// Assertion macros shared by the entry point decoder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SMBIOS_ENTRY_POINT_DECODER_DEFINES_SVH
`define SMBIOS_ENTRY_POINT_DECODER_DEFINES_SVH

`ifndef SYNTH
// Check sampled on the clock, masked while reset is asserted
`define SEPD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check sampled on the clock, live during reset as well
`define SEPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SEPD_ASSERT(label, clk, rstn, prop, msg)
`define SEPD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/sepd_pkg.sv]
// Package for the entry point decoder: constants, register indexes and types.
// No dependencies; used by every module of the block.
package sepd_pkg;

    localparam int STORE_DEPTH_DEF = 32;
    localparam int CNT_W           = $clog2(STORE_DEPTH_DEF + 2);

    // Entry point layout limits
    localparam int MIN_BYTES      = 7;
    localparam int LONG_LEN_MIN   = 24;
    localparam int SHORT_LEN_MIN  = 31;
    localparam int LEN_MAX        = 32;
    localparam int INTER_FIRST    = 16;
    localparam int INTER_END      = 31;
    localparam int LONG_MAJOR_MIN = 3;
    localparam int SHORT_MAJOR_MIN = 2;

    // Anchors, offset zero in the low byte
    localparam logic [39:0] ANCHOR_LONG  = 40'h5F_33_4D_53_5F; // "_SM3_"
    localparam logic [31:0] ANCHOR_SHORT = 32'h5F_4D_53_5F;    // "_SM_"
    localparam logic [39:0] ANCHOR_MID   = 40'h5F_49_4D_44_5F; // "_DMI_"

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TABLE_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STRUCTURES  = 1'd1;
    localparam logic [31:0] MAX_TABLE_BYTES_RST = 32'd1048576;
    localparam logic [15:0] MAX_STRUCTURES_RST  = 16'd1024;

    // Finished run handed from capture to decode
    typedef struct packed {
        logic             pending;
        logic [CNT_W-1:0] avail;
        logic [7:0]       entry_sum;
        logic [7:0]       inter_sum;
    } decide_req_t;

    // One decoded result
    typedef struct packed {
        logic        decode_ok;
        logic        long_form;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [31:0] table_length;
        logic [63:0] table_address;
        logic [15:0] structure_count;
    } result_t;

endpackage

[rtl/sepd_capture.sv]
// Byte capture: entry point store, byte count and running checksums.
// Depends on sepd_pkg; hands a finished run to sepd_decode.
module sepd_capture #(
    parameter int STORE_DEPTH = sepd_pkg::STORE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            entry_byte,
    input  logic                  last_byte,
    input  logic                  advance,
    output logic [7:0]            store [STORE_DEPTH],
    output sepd_pkg::decide_req_t decide
);
    import sepd_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(STORE_DEPTH + 1);

    logic [7:0]       store_reg [STORE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       esum_reg, esum_next;
    logic [7:0]       isum_reg, isum_next;
    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] avail_reg, avail_next;
    logic [7:0]       esum_snap_reg, esum_snap_next;
    logic [7:0]       isum_snap_reg, isum_snap_next;

    logic             in_store;
    logic [7:0]       stored_len;
    logic             add_entry, add_inter;
    logic [7:0]       esum_acc, isum_acc;
    logic [CNT_W-1:0] count_inc;

    // Declared length from the anchor already held in the store
    always_comb begin
        if ({store_reg[4], store_reg[3], store_reg[2], store_reg[1], store_reg[0]}
                == ANCHOR_LONG) begin
            stored_len = store_reg[6];
        end else if ({store_reg[3], store_reg[2], store_reg[1], store_reg[0]}
                == ANCHOR_SHORT) begin
            stored_len = store_reg[5];
        end else begin
            stored_len = 8'd0;
        end
    end

    // Per-byte sums and count
    always_comb begin
        in_store  = count_reg < CNT_W'(STORE_DEPTH);
        add_entry = in_store && ((count_reg < CNT_W'(MIN_BYTES))
                                 || (8'(count_reg) < stored_len));
        add_inter = in_store && (count_reg >= CNT_W'(INTER_FIRST))
                             && (count_reg < CNT_W'(INTER_END));
        esum_acc  = esum_reg + (add_entry ? entry_byte : 8'd0);
        isum_acc  = isum_reg + (add_inter ? entry_byte : 8'd0);
        count_inc = (count_reg == COUNT_SAT) ? count_reg : count_reg + CNT_W'(1);
    end

    // Next state of the run and of the finished-run snapshot
    always_comb begin
        count_next     = count_reg;
        esum_next      = esum_reg;
        isum_next      = isum_reg;
        avail_next     = avail_reg;
        esum_snap_next = esum_snap_reg;
        isum_snap_next = isum_snap_reg;
        pending_next   = advance ? 1'b0 : pending_reg;
        if (in_accept) begin
            if (last_byte) begin
                count_next     = '0;
                esum_next      = 8'd0;
                isum_next      = 8'd0;
                avail_next     = count_inc;
                esum_snap_next = esum_acc;
                isum_snap_next = isum_acc;
                pending_next   = 1'b1;
            end else begin
                count_next = count_inc;
                esum_next  = esum_acc;
                isum_next  = isum_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            esum_reg    <= 8'd0;
            isum_reg    <= 8'd0;
            pending_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            esum_reg    <= esum_next;
            isum_reg    <= isum_next;
            pending_reg <= pending_next;
        end
    end

    // Snapshot payload, no reset
    always_ff @(posedge aclk) begin
        avail_reg     <= avail_next;
        esum_snap_reg <= esum_snap_next;
        isum_snap_reg <= isum_snap_next;
    end

    // Byte store, first STORE_DEPTH bytes of a run
    always_ff @(posedge aclk) begin
        if (in_accept && in_store) begin
            store_reg[count_reg[IDX_W-1:0]] <= entry_byte;
        end
    end

    assign store            = store_reg;
    assign decide.pending   = pending_reg;
    assign decide.avail     = avail_reg;
    assign decide.entry_sum = esum_snap_reg;
    assign decide.inter_sum = isum_snap_reg;

endmodule

[rtl/sepd_decode.sv]
// Decode of a finished run: anchor, length, checksum, version and range checks.
// Depends on sepd_pkg; reads the store and snapshot from sepd_capture.
module sepd_decode #(
    parameter int STORE_DEPTH = sepd_pkg::STORE_DEPTH_DEF
) (
    input  logic [7:0]            store [STORE_DEPTH],
    input  sepd_pkg::decide_req_t decide,
    input  logic [31:0]           max_table_bytes,
    input  logic [15:0]           max_structures,
    output sepd_pkg::result_t     result
);
    import sepd_pkg::*;

    logic       enough;
    logic       is_long, is_short, mid_ok;
    logic [7:0] avail_b;
    logic       long_ok, short_ok;
    result_t    dec;

    always_comb begin
        avail_b  = 8'(decide.avail);
        enough   = decide.avail >= CNT_W'(MIN_BYTES);
        is_long  = {store[4], store[3], store[2], store[1], store[0]} == ANCHOR_LONG;
        is_short = {store[3], store[2], store[1], store[0]} == ANCHOR_SHORT;
        mid_ok   = {store[20], store[19], store[18], store[17], store[16]} == ANCHOR_MID;

        // Structural checks for each form
        long_ok  = enough && is_long
                   && (store[6] >= 8'(LONG_LEN_MIN)) && (store[6] <= 8'(LEN_MAX))
                   && (store[6] <= avail_b) && (decide.entry_sum == 8'd0)
                   && (store[7] >= 8'(LONG_MAJOR_MIN));
        short_ok = enough && !is_long && is_short
                   && (store[5] >= 8'(SHORT_LEN_MIN)) && (store[5] <= 8'(LEN_MAX))
                   && (store[5] <= avail_b) && (decide.entry_sum == 8'd0)
                   && mid_ok && (decide.inter_sum == 8'd0)
                   && (store[6] >= 8'(SHORT_MAJOR_MIN));
    end

    // Field extraction, zero on structural failure
    always_comb begin
        dec = '0;
        if (long_ok) begin
            dec.long_form     = 1'b1;
            dec.version_major = store[7];
            dec.version_minor = store[8];
            dec.table_length  = {store[15], store[14], store[13], store[12]};
            dec.table_address = {store[23], store[22], store[21], store[20],
                                 store[19], store[18], store[17], store[16]};
        end else if (short_ok) begin
            dec.version_major   = store[6];
            dec.version_minor   = store[7];
            dec.table_length    = {16'd0, store[23], store[22]};
            dec.table_address   = {32'd0, store[27], store[26], store[25], store[24]};
            dec.structure_count = {store[29], store[28]};
        end
        // Range limits clear ok only
        dec.decode_ok = (long_ok || short_ok)
                        && (dec.table_address != 64'd0)
                        && (dec.table_length != 32'd0)
                        && (dec.table_length <= max_table_bytes)
                        && ((dec.structure_count == 16'd0)
                            || (dec.structure_count <= max_structures));
    end

    assign result = dec;

endmodule

[rtl/smbios_entry_point_decoder.sv]
// Top level of the entry point decoder: ports, configuration and result register.
// Depends on sepd_pkg, sepd_capture, sepd_decode and the assertion macro header.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+----------------------------------------
//  s_       | in  | s_tvalid/s_tready | s_tdata entry byte, s_tlast final byte
//  m_       | out | m_tvalid/m_tready | m_tdata decoded fields, m_tuser flags
//  cfg_     | in  | cfg_wr_en         | cfg_index, cfg_wdata
//
// One byte is taken per cycle while s_tready is high. A final byte is registered into
// the pending snapshot and decoded from it; its result lands in the output register
// once that register is free, and m_tvalid rises with it.
// While a result waits in the output register the next run keeps streaming in;
// input stalls only when a decoded run and the output register are both held.
// Reset (aresetn low, synchronous) empties the pipeline and restores limits.
`include "smbios_entry_point_decoder_defines.svh"

module smbios_entry_point_decoder #(
    parameter int STORE_DEPTH = sepd_pkg::STORE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] entry_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] version_major, [15:8] version_minor, [47:16] table_length,
    // [111:48] table_address, [127:112] structure_count
    output logic [127:0]                   m_tdata,
    output logic [1:0]                     m_tuser,   // [0] decode_ok, [1] long_form
    input  logic                           cfg_wr_en,
    input  logic [sepd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata
);
    import sepd_pkg::*;

    logic [7:0]  store [STORE_DEPTH];
    decide_req_t decide;
    result_t     result;

    logic        in_accept, out_ready, advance;
    logic        m_tvalid_reg, m_tvalid_next;
    result_t     out_reg;
    logic [31:0] max_table_bytes_reg, max_table_bytes_next;
    logic [15:0] max_structures_reg, max_structures_next;

    // Handshake control
    assign out_ready = !m_tvalid_reg || m_tready;
    assign advance   = decide.pending && out_ready;
    assign s_tready  = !decide.pending || out_ready;
    assign in_accept = s_tvalid && s_tready;

    sepd_capture #(.STORE_DEPTH(STORE_DEPTH)) u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .entry_byte (s_tdata),
        .last_byte  (s_tlast),
        .advance    (advance),
        .store      (store),
        .decide     (decide)
    );

    sepd_decode #(.STORE_DEPTH(STORE_DEPTH)) u_decode (
        .store           (store),
        .decide          (decide),
        .max_table_bytes (max_table_bytes_reg),
        .max_structures  (max_structures_reg),
        .result          (result)
    );

    // Configuration writes
    always_comb begin
        max_table_bytes_next = max_table_bytes_reg;
        max_structures_next  = max_structures_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_TABLE_BYTES: max_table_bytes_next = cfg_wdata;
                REG_MAX_STRUCTURES:  max_structures_next  = cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Output valid
    always_comb begin
        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg        <= 1'b0;
            max_table_bytes_reg <= MAX_TABLE_BYTES_RST;
            max_structures_reg  <= MAX_STRUCTURES_RST;
        end else begin
            m_tvalid_reg        <= m_tvalid_next;
            max_table_bytes_reg <= max_table_bytes_next;
            max_structures_reg  <= max_structures_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_reg.long_form, out_reg.decode_ok};
    assign m_tdata  = {out_reg.structure_count, out_reg.table_address,
                       out_reg.table_length, out_reg.version_minor,
                       out_reg.version_major};

    // Checks
    `SEPD_ASSERT(a_last_makes_pending, aclk, aresetn, in_accept && s_tlast |=> decide.pending, "final byte did not start a decode")
    `SEPD_ASSERT(a_valid_from_advance, aclk, aresetn, $rose(m_tvalid) |-> $past(advance), "result appeared without a decode")
    `SEPD_ASSERT(a_ok_limits, aclk, aresetn, m_tvalid && m_tuser[0] |-> (out_reg.table_address != 64'd0) && (out_reg.table_length != 32'd0), "ok result with empty table")
    `SEPD_ASSERT(a_long_no_count, aclk, aresetn, m_tvalid && m_tuser[1] |-> out_reg.structure_count == 16'd0, "64-bit form with structure count")
    `SEPD_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid && !decide.pending, "reset left work in flight")

endmodule
